/* rtl/etrb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrb_pkg
// Shared types and codes for the event trace ring buffer.
// ----------------------------------------------------------------------------
package etrb_pkg;

   localparam int RING_DEPTH_DEFAULT = 64;
   localparam int LIVE_W             = 7;

   localparam logic CMD_APPEND   = 1'b0;
   localparam logic CMD_SNAPSHOT = 1'b1;

   localparam logic [1:0] ST_APPENDED = 2'd0;
   localparam logic [1:0] ST_REJECTED = 2'd1;
   localparam logic [1:0] ST_RECORD   = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic              command;
      logic [31:0]       kind;
      logic [63:0]       arg_first;
      logic [63:0]       arg_second;
      logic [63:0]       timestamp;
      logic [LIVE_W-1:0] read_limit;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [31:0]       rec_kind;
      logic [63:0]       rec_tick;
      logic [63:0]       rec_arg_first;
      logic [63:0]       rec_arg_second;
      logic              last;
      logic [63:0]       total_records;
      logic [LIVE_W-1:0] live_count;
   } rsp_type;

   typedef struct packed {
      logic take_req;
      logic load_rec;
   } etrb_cmd_type;

   typedef struct packed {
      logic out_free;
      logic walk_go;
      logic rec_last;
   } etrb_sts_type;

endpackage

/* rtl/etrb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrb_datapath
// Record store, slot valid bits, append total, walk pointer and result
// register of the trace ring buffer.
// ----------------------------------------------------------------------------
module etrb_datapath import etrb_pkg::*; #(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_data,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  etrb_cmd_type cmd,
   output etrb_sts_type sts
);

   localparam int                PTR_W      = $clog2(RING_DEPTH);
   localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(RING_DEPTH - 1);
   localparam logic [LIVE_W-1:0] DEPTH_LIVE = LIVE_W'(RING_DEPTH);

   typedef struct packed {
      logic [31:0] kind;
      logic [63:0] tick;
      logic [63:0] arg_first;
      logic [63:0] arg_second;
   } slot_type;

   slot_type mem [RING_DEPTH];
   slot_type rd_data_ff;

   logic [RING_DEPTH-1:0] valid_ff, valid_in;
   logic [63:0]           total_ff, total_in, total_inc;
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in, wr_next;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in, rd_next, rd_addr, oldest;
   logic [LIVE_W-1:0]     remain_ff, remain_in, live, live_inc, count;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  below_depth, is_append, kind_zero, mem_we, rd_en;

   assign below_depth = total_ff < 64'(RING_DEPTH);
   assign live        = below_depth ? total_ff[LIVE_W-1:0] : DEPTH_LIVE;
   assign total_inc   = total_ff + 64'd1;
   assign live_inc    = (total_inc < 64'(RING_DEPTH)) ? total_inc[LIVE_W-1:0] : DEPTH_LIVE;
   assign wr_next     = (total_inc == 64'd0 || wr_ptr_ff == PTR_LAST) ? '0
                        : wr_ptr_ff + PTR_W'(1);
   assign oldest      = below_depth ? '0 : wr_ptr_ff;
   assign count       = (live < req_data.read_limit) ? live : req_data.read_limit;
   assign is_append   = req_data.command == CMD_APPEND;
   assign kind_zero   = req_data.kind == 32'd0;
   assign rd_next     = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign sts.walk_go  = !is_append && count != '0 && valid_ff[oldest];
   assign sts.rec_last = remain_ff == LIVE_W'(1) || !valid_ff[rd_next];

   assign mem_we  = cmd.take_req && is_append && !kind_zero;
   assign rd_en   = (cmd.take_req && sts.walk_go) || cmd.load_rec;
   assign rd_addr = cmd.take_req ? oldest : rd_next;

   always_comb begin
      valid_in     = valid_ff;
      total_in     = total_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      remain_in    = remain_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.take_req) begin
         rsp_in                = '0;
         rsp_in.last           = 1'b1;
         rsp_in.total_records  = total_ff;
         rsp_in.live_count     = live;
         if (is_append) begin
            rsp_valid_in = 1'b1;
            if (kind_zero) begin
               rsp_in.status = ST_REJECTED;
            end else begin
               valid_in[wr_ptr_ff]  = 1'b1;
               total_in             = total_inc;
               wr_ptr_in            = wr_next;
               rsp_in.status        = ST_APPENDED;
               rsp_in.total_records = total_inc;
               rsp_in.live_count    = live_inc;
            end
         end else if (sts.walk_go) begin
            rd_ptr_in = oldest;
            remain_in = count;
            rsp_in    = rsp_ff;
         end else begin
            rsp_valid_in  = 1'b1;
            rsp_in.status = ST_EMPTY;
         end
      end else if (cmd.load_rec) begin
         rsp_valid_in          = 1'b1;
         rsp_in.status         = ST_RECORD;
         rsp_in.rec_kind       = rd_data_ff.kind;
         rsp_in.rec_tick       = rd_data_ff.tick;
         rsp_in.rec_arg_first  = rd_data_ff.arg_first;
         rsp_in.rec_arg_second = rd_data_ff.arg_second;
         rsp_in.last           = sts.rec_last;
         rsp_in.total_records  = total_ff;
         rsp_in.live_count     = live;
         rd_ptr_in             = rd_next;
         remain_in             = remain_ff - LIVE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         total_ff     <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (mem_we) begin
         mem[wr_ptr_ff] <= '{kind:       req_data.kind,
                             tick:       req_data.timestamp,
                             arg_first:  req_data.arg_first,
                             arg_second: req_data.arg_second};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/etrb_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrb_controller
// Sequencer for the trace ring buffer: takes requests and steps the
// oldest-first snapshot walk.
// ----------------------------------------------------------------------------
module etrb_controller import etrb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  etrb_sts_type sts,
   output etrb_cmd_type cmd
);

   typedef enum logic {
      IDLE,
      WALK
   } state_type;

   state_type state_ff, state_in;

   assign req_ready    = state_ff == IDLE && sts.out_free;
   assign cmd.take_req = req_ready && req_valid;
   assign cmd.load_rec = state_ff == WALK && sts.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (cmd.take_req && sts.walk_go) begin
               state_in = WALK;
            end
         end
         WALK: begin
            if (cmd.load_rec && sts.rec_last) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/event_trace_ring_buffer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_trace_ring_buffer_unit
// Circular trace store of the most recent RING_DEPTH event records.
// ----------------------------------------------------------------------------
// An append (accepted or rejected) returns one result; appends stream at
// one per cycle while the result side keeps up. A snapshot returns its
// records paced by the single read port of the record memory: each is
// read into the read register, then loaded into the result register, and
// the walk holds while the result side stalls. An empty snapshot returns
// its one result like an append. The next request is taken once idle and
// the result register is free after a snapshot's final record is loaded.
// Slot valid bits clear together at reset, so there is no clearing pass.
// ----------------------------------------------------------------------------
module event_trace_ring_buffer_unit import etrb_pkg::*; #(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   etrb_cmd_type cmd;
   etrb_sts_type sts;

   etrb_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   etrb_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

/* rtl/etrb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrb_checker
// Port-level checks for the trace ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module etrb_checker import etrb_pkg::*; #(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic [LIVE_W-1:0] live_expect;

   assign live_expect = (rsp_data.total_records < 64'(RING_DEPTH))
                        ? rsp_data.total_records[LIVE_W-1:0] : LIVE_W'(RING_DEPTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_live_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.live_count == live_expect)
      else $error("live count does not follow total");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_APPENDED || rsp_data.status == ST_REJECTED ||
                    rsp_data.status == ST_EMPTY) |-> rsp_data.last)
      else $error("single result without last");

   a_record_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_RECORD |-> rsp_data.rec_kind != 32'd0)
      else $error("returned record with zero kind");

   a_no_req_midwalk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.status == ST_RECORD && !rsp_data.last
      |-> !req_ready)
      else $error("request taken during snapshot");

endmodule

bind event_trace_ring_buffer_unit etrb_checker #(
   .RING_DEPTH (RING_DEPTH)
) u_etrb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* verif/event_trace_ring_buffer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_trace_ring_buffer_checker
// Watches both channels of the trace ring buffer and scores every result.
// ----------------------------------------------------------------------------
// Each request transfer runs through a private copy of the ring (kinds,
// ticks, arguments and the 64-bit append total), and the results it should
// cause are queued in order. Each result transfer is compared field by
// field with the oldest queued entry. The mismatch count and the number of
// results still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module event_trace_ring_buffer_checker import etrb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      outstanding
);

   localparam int DEPTH = RING_DEPTH_DEFAULT;

   logic [31:0] ring_kind  [DEPTH];
   logic [63:0] ring_tick  [DEPTH];
   logic [63:0] ring_arg_a [DEPTH];
   logic [63:0] ring_arg_b [DEPTH];
   logic [63:0] append_total;
   rsp_type     owed_results_q [$];

   function automatic logic [LIVE_W-1:0] live_records();
      return (append_total < 64'(DEPTH)) ? append_total[LIVE_W-1:0] : LIVE_W'(DEPTH);
   endfunction

   function automatic rsp_type trace_result(logic [1:0] status, logic [31:0] kind,
                                            logic [63:0] tick, logic [63:0] arg_a,
                                            logic [63:0] arg_b, logic last);
      rsp_type res;
      res.status         = status;
      res.rec_kind       = kind;
      res.rec_tick       = tick;
      res.rec_arg_first  = arg_a;
      res.rec_arg_second = arg_b;
      res.last           = last;
      res.total_records  = append_total;
      res.live_count     = live_records();
      return res;
   endfunction

   task automatic predict_trace_results(input req_type r);
      logic [63:0] live;
      logic [63:0] count;
      logic [63:0] oldest;
      int          src;
      int          given;
      bit          stopped;
      given   = 0;
      stopped = 1'b0;
      if (r.command == CMD_APPEND) begin
         if (r.kind == '0) begin
            owed_results_q.push_back(trace_result(ST_REJECTED, '0, '0, '0, '0, 1'b1));
         end else begin
            src             = int'(append_total % 64'(DEPTH));
            ring_kind[src]  = r.kind;
            ring_tick[src]  = r.timestamp;
            ring_arg_a[src] = r.arg_first;
            ring_arg_b[src] = r.arg_second;
            append_total    = append_total + 64'd1;
            owed_results_q.push_back(trace_result(ST_APPENDED, '0, '0, '0, '0, 1'b1));
         end
      end else begin
         live   = 64'(live_records());
         count  = (live < 64'(r.read_limit)) ? live : 64'(r.read_limit);
         oldest = (append_total < 64'(DEPTH)) ? 64'd0 : append_total % 64'(DEPTH);
         for (int i = 0; i < int'(count); i++) begin
            src = int'((oldest + 64'(i)) % 64'(DEPTH));
            if (ring_kind[src] == '0)
               stopped = 1'b1;
            if (!stopped) begin
               owed_results_q.push_back(trace_result(ST_RECORD, ring_kind[src],
                  ring_tick[src], ring_arg_a[src], ring_arg_b[src], 1'b0));
               given++;
            end
         end
         if (given == 0)
            owed_results_q.push_back(trace_result(ST_EMPTY, '0, '0, '0, '0, 1'b1));
         else
            owed_results_q[owed_results_q.size() - 1].last = 1'b1;
      end
   endtask

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++)
            ring_kind[i] = '0;
         append_total   = '0;
         mismatch_count = 0;
         owed_results_q.delete();
      end else begin
         if (req_valid && req_ready)
            predict_trace_results(req_data);
         if (rsp_valid && rsp_ready) begin
            if (owed_results_q.size() == 0) begin
               $error("result transfer with none expected, status %0d", rsp_data.status);
               mismatch_count++;
            end else begin
               want = owed_results_q.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_data.status));
               check_field("rec_kind", 64'(want.rec_kind), 64'(rsp_data.rec_kind));
               check_field("rec_tick", want.rec_tick, rsp_data.rec_tick);
               check_field("rec_arg_first", want.rec_arg_first, rsp_data.rec_arg_first);
               check_field("rec_arg_second", want.rec_arg_second, rsp_data.rec_arg_second);
               check_field("last", 64'(want.last), 64'(rsp_data.last));
               check_field("total_records", want.total_records, rsp_data.total_records);
               check_field("live_count", 64'(want.live_count), 64'(rsp_data.live_count));
            end
         end
      end
      outstanding = owed_results_q.size();
   end

endmodule

/* verif/event_trace_ring_buffer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_trace_ring_buffer_unit_tb
// Stimulus and verdict for the event trace ring buffer.
// ----------------------------------------------------------------------------
// A directed opening covers empty snapshots, zero-kind rejects, field
// extremes and snapshot limits at zero, one, exact and above the live
// count. A random mix of appends, rejects and snapshots then wraps the
// ring. The result side stalls at random and once for a
// long stretch so the block backs up; the request side idles at random
// and once waits for a full drain. Scoring is done by the checker.
// ----------------------------------------------------------------------------
module event_trace_ring_buffer_unit_tb;
   import etrb_pkg::*;

   localparam int RANDOM_REQUESTS = 157;
   localparam int LONG_STALL      = 150;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      mismatch_count;
   int      outstanding;

   bit      stall_go;
   bit      calm;
   int      n_appends;
   int      n_rejects;
   int      n_snapshots;

   event_trace_ring_buffer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   event_trace_ring_buffer_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $error("run timed out with %0d results still owed", outstanding);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic req_type append_req(logic [31:0] kind, logic [63:0] arg_a,
                                          logic [63:0] arg_b, logic [63:0] tick);
      req_type r;
      r.command    = CMD_APPEND;
      r.kind       = kind;
      r.arg_first  = arg_a;
      r.arg_second = arg_b;
      r.timestamp  = tick;
      r.read_limit = LIVE_W'($urandom_range(0, 64));
      return r;
   endfunction

   function automatic req_type snapshot_req(int limit);
      req_type r;
      r            = append_req($urandom, {$urandom, $urandom}, {$urandom, $urandom},
                                {$urandom, $urandom});
      r.command    = CMD_SNAPSHOT;
      r.read_limit = LIVE_W'(limit);
      return r;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int      roll;
      roll = $urandom_range(0, 99);
      r    = append_req($urandom, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom});
      if (roll < 60) begin
         if (roll < 10)
            r.kind = $urandom_range(1, 255);
         if (r.kind == '0)
            r.kind = 32'd1;
      end else if (roll < 68) begin
         r.kind = '0;
      end else begin
         r.command = CMD_SNAPSHOT;
         if ($urandom_range(0, 3) == 0)
            r.read_limit = LIVE_W'(64);
      end
      return r;
   endfunction

   task automatic send_request(input req_type item);
      if (!calm && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
      if (item.command == CMD_SNAPSHOT)
         n_snapshots++;
      else if (item.kind == '0)
         n_rejects++;
      else
         n_appends++;
   endtask

   task automatic wait_drained(input int limit);
      req_valid <= 1'b0;
      @(negedge clock);
      for (int w = 0; w < limit && outstanding != 0; w++)
         @(negedge clock);
   endtask

   initial begin
      bit held;
      rsp_ready = 1'b0;
      held      = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (stall_go && !held) begin
            rsp_ready <= 1'b0;
            repeat (LONG_STALL) @(negedge clock);
            held = 1'b1;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= 13);
         end
      end
   end

   initial begin
      logic [63:0] ones;
      logic [63:0] alt;
      ones        = '1;
      alt         = {16{4'hA}};
      req_valid   = 1'b0;
      req_data    = '0;
      stall_go    = 1'b0;
      calm        = 1'b0;
      n_appends   = 0;
      n_rejects   = 0;
      n_snapshots = 0;
      reset       = 1'b1;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(snapshot_req(64));
      send_request(snapshot_req(0));
      send_request(append_req('0, ones, ones, ones));
      send_request(append_req('1, ones, ones, ones));
      send_request(append_req(32'd1, '0, '0, '0));
      send_request(append_req(32'hAAAA_AAAA, ~alt, ~alt, alt));
      send_request(append_req(32'h5555_5555, alt, alt, ~alt));
      send_request(append_req('0, '0, '0, '0));
      send_request(snapshot_req(0));
      send_request(snapshot_req(1));
      send_request(snapshot_req(64));
      send_request(snapshot_req(4));
      send_request(snapshot_req(2));
      wait_drained(5000);

      stall_go = 1'b1;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         calm = (i >= 60 && i < 100);
         send_request(random_req());
      end
      calm = 1'b0;

      wait_drained(20000);
      repeat (20) @(negedge clock);
      if (outstanding != 0)
         $error("%0d expected results never arrived", outstanding);
      $display("Sent %0d appends, %0d zero-kind rejects and %0d snapshots",
               n_appends, n_rejects, n_snapshots);
      $display("with random stalls, one long result stall and one full drain pause");
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/etrb_pkg.sv
rtl/etrb_datapath.sv
rtl/etrb_controller.sv
rtl/event_trace_ring_buffer_unit.sv
rtl/etrb_checker.sv
verif/event_trace_ring_buffer_checker.sv
verif/event_trace_ring_buffer_unit_tb.sv
